@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while out of reset
`define GLI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property at every edge, reset included
`define GLI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

@@ rtl/gli_pkg.sv @@
// ----------------------------------------------------------------------------
// gli_pkg
// Sizes, field widths and codes shared by the grid inpainting block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gli_pkg;

    // Grid size limits
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 9;
    localparam int ADDR_W   = 2;

    // Position and count widths
    localparam int W_IDX_W = $clog2(MAX_WIDTH);
    localparam int H_IDX_W = $clog2(MAX_HEIGHT);
    localparam int W_CNT_W = $clog2(MAX_WIDTH + 1);
    localparam int H_CNT_W = $clog2(MAX_HEIGHT + 1);

    // Ramp span and numerator widths
    localparam int D_W   = (W_IDX_W > H_IDX_W) ? W_IDX_W : H_IDX_W;
    localparam int NUM_W = SAMPLE_W + D_W;

    // Register indexes
    typedef enum logic [ADDR_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_HORIZ_ENABLE = 2'd2,
        REG_VERT_ENABLE  = 2'd3
    } cfg_reg_t;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

endpackage

@@ rtl/gli_div.sv @@
// ----------------------------------------------------------------------------
// gli_div
// Restoring serial divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gli_div import gli_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_W-1:0]    num,
    input  logic [D_W-1:0]      den,
    output logic                done,
    output logic [SAMPLE_W-1:0] quo
);

    localparam int CNT_W = $clog2(SAMPLE_W + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [D_W-1:0]      rem_reg;
    logic [D_W-1:0]      den_reg;
    logic [SAMPLE_W-1:0] quo_reg;

    logic [D_W:0]        trial;
    logic [D_W:0]        diff;
    logic                fits;
    logic [D_W-1:0]      rem_next;

    // Trial subtract of the divisor from the shifted remainder
    always_comb begin
        trial    = {rem_reg, quo_reg[SAMPLE_W-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? diff[D_W-1:0] : trial[D_W-1:0];
    end

    // Step counter and completion flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SAMPLE_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift; the top bits of the numerator stay below den
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num[NUM_W-1 -: D_W];
            quo_reg <= num[SAMPLE_W-1:0];
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[SAMPLE_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

@@ rtl/grid_linear_inpaint.sv @@
// ----------------------------------------------------------------------------
// grid_linear_inpaint
// Border-only grid store with linear ramp fill on drain.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry s_cmd and s_sample on a valid/ready channel. A load word
//   (s_cmd = 0) stores one raster sample; only border samples are kept. A
//   drain word (s_cmd = 1) returns one processed sample on the m_ channel,
//   with m_last high on the final sample of the grid. A drain word passes
//   the read state, then goes straight to the finish state for a grid of
//   width or height 2 or less; else each ramp, one in horizontal or vertical
//   mode and two in averaged mode, runs the shared multiplier and then the
//   16-step serial divider. s_ready is low while a drain word is in work and
//   rises at the same edge that writes the result. The result register holds
//   a finished word while m_ready is low; loads are still taken meanwhile,
//   and a following drain waits before writing it.
//   Configuration writes via cfg_we/cfg_addr/cfg_wdata; a size write returns
//   load and drain positions to the first sample. Reset restores a 256 by 256
//   grid in averaged mode with positions at the first sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module grid_linear_inpaint import gli_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_cmd,
    input  logic [SAMPLE_W-1:0] s_sample,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SAMPLE_W-1:0] m_value,
    output logic                m_last
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_READ = 6'b000010,
        ST_MULA = 6'b000100,
        ST_MULB = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    // Configuration
    logic [CFG_W-1:0]    frame_width_reg;
    logic [CFG_W-1:0]    frame_height_reg;
    logic                horiz_en_reg;
    logic                vert_en_reg;

    // Positions
    logic [W_IDX_W-1:0]  load_x_reg;
    logic [H_IDX_W-1:0]  load_y_reg;
    logic [W_IDX_W-1:0]  drain_x_reg;
    logic [H_IDX_W-1:0]  drain_y_reg;

    // Sequencer
    state_t              state_reg;
    state_t              state_next;
    logic                phase_v_reg;
    logic                phase_v_next;

    // Border stores and read registers
    logic [SAMPLE_W-1:0] top_mem    [MAX_WIDTH];
    logic [SAMPLE_W-1:0] bottom_mem [MAX_WIDTH];
    logic [SAMPLE_W-1:0] left_mem   [MAX_HEIGHT];
    logic [SAMPLE_W-1:0] right_mem  [MAX_HEIGHT];
    logic [SAMPLE_W-1:0] rd_top_reg;
    logic [SAMPLE_W-1:0] rd_bottom_reg;
    logic [SAMPLE_W-1:0] rd_left_reg;
    logic [SAMPLE_W-1:0] rd_right_reg;

    // Datapath
    logic [NUM_W-1:0]    prod_reg;
    logic [SAMPLE_W-1:0] hv_reg;
    logic [SAMPLE_W-1:0] vv_reg;
    logic                m_valid_reg;
    logic [SAMPLE_W-1:0] m_value_reg;
    logic                m_last_reg;

    logic [W_CNT_W-1:0]  w_eff;
    logic [H_CNT_W-1:0]  h_eff;
    logic [W_IDX_W-1:0]  d_w;
    logic [H_IDX_W-1:0]  d_h;
    logic                small_grid;
    logic                mode_h;
    logic                mode_v;
    logic                mode_avg;
    logic                in_accept;
    logic                load_accept;
    logic                drain_accept;
    logic                out_free;
    logic                fin_write;
    logic                size_write;

    logic [SAMPLE_W-1:0] ramp_a;
    logic [SAMPLE_W-1:0] ramp_b;
    logic [D_W-1:0]      ramp_pos;
    logic [D_W-1:0]      ramp_d;
    logic [SAMPLE_W-1:0] mul_a;
    logic [D_W-1:0]      mul_b;
    logic [NUM_W-1:0]    mul_p;
    logic [NUM_W-1:0]    div_num;
    logic                div_start;
    logic                div_done;
    logic [SAMPLE_W-1:0] div_quo;

    logic [SAMPLE_W-1:0] pass_value;
    logic [SAMPLE_W:0]   avg_sum;
    logic [SAMPLE_W-1:0] result_value;
    logic                result_last;

    // Effective grid size: zero acts as one, oversize clamps to the maximum
    always_comb begin
        if (frame_width_reg == '0) begin
            w_eff = W_CNT_W'(1);
        end else if (32'(frame_width_reg) > MAX_WIDTH) begin
            w_eff = W_CNT_W'(MAX_WIDTH);
        end else begin
            w_eff = W_CNT_W'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            h_eff = H_CNT_W'(1);
        end else if (32'(frame_height_reg) > MAX_HEIGHT) begin
            h_eff = H_CNT_W'(MAX_HEIGHT);
        end else begin
            h_eff = H_CNT_W'(frame_height_reg);
        end
    end

    assign d_w        = W_IDX_W'(w_eff - W_CNT_W'(1));
    assign d_h        = H_IDX_W'(h_eff - H_CNT_W'(1));
    assign small_grid = (w_eff <= W_CNT_W'(2)) || (h_eff <= H_CNT_W'(2));
    assign mode_h     = horiz_en_reg && !vert_en_reg;
    assign mode_v     = !horiz_en_reg && vert_en_reg;
    assign mode_avg   = !mode_h && !mode_v;

    // Handshake
    assign s_ready      = (state_reg == ST_IDLE);
    assign in_accept    = s_valid && s_ready;
    assign load_accept  = in_accept && (s_cmd == CMD_LOAD);
    assign drain_accept = in_accept && (s_cmd == CMD_DRAIN);
    assign out_free     = !m_valid_reg || m_ready;
    assign fin_write    = (state_reg == ST_FIN) && out_free;
    assign size_write   = cfg_we && ((cfg_addr == REG_FRAME_WIDTH) ||
                                     (cfg_addr == REG_FRAME_HEIGHT));

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= CFG_W'(256);
            frame_height_reg <= CFG_W'(256);
            horiz_en_reg     <= 1'b1;
            vert_en_reg      <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                REG_HORIZ_ENABLE: horiz_en_reg     <= cfg_wdata[0];
                REG_VERT_ENABLE:  vert_en_reg      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Advance load and drain positions in raster order; size writes rewind
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_x_reg  <= '0;
            load_y_reg  <= '0;
            drain_x_reg <= '0;
            drain_y_reg <= '0;
        end else if (size_write) begin
            load_x_reg  <= '0;
            load_y_reg  <= '0;
            drain_x_reg <= '0;
            drain_y_reg <= '0;
        end else begin
            if (load_accept) begin
                if (load_x_reg == d_w) begin
                    load_x_reg <= '0;
                    load_y_reg <= (load_y_reg == d_h) ? '0 : load_y_reg + H_IDX_W'(1);
                end else begin
                    load_x_reg <= load_x_reg + W_IDX_W'(1);
                end
            end
            if (fin_write) begin
                if (drain_x_reg == d_w) begin
                    drain_x_reg <= '0;
                    drain_y_reg <= (drain_y_reg == d_h) ? '0 : drain_y_reg + H_IDX_W'(1);
                end else begin
                    drain_x_reg <= drain_x_reg + W_IDX_W'(1);
                end
            end
        end
    end

    // Border stores: write border samples on load, read all four on drain
    always_ff @(posedge aclk) begin
        if (load_accept) begin
            if (load_y_reg == '0) begin
                top_mem[load_x_reg] <= s_sample;
            end
            if (load_y_reg == d_h) begin
                bottom_mem[load_x_reg] <= s_sample;
            end
            if (load_x_reg == '0) begin
                left_mem[load_y_reg] <= s_sample;
            end
            if (load_x_reg == d_w) begin
                right_mem[load_y_reg] <= s_sample;
            end
        end
        if (drain_accept) begin
            rd_top_reg    <= top_mem[drain_x_reg];
            rd_bottom_reg <= bottom_mem[drain_x_reg];
            rd_left_reg   <= left_mem[drain_y_reg];
            rd_right_reg  <= right_mem[drain_y_reg];
        end
    end

    // Ramp operands for the current phase
    always_comb begin
        if (phase_v_reg) begin
            ramp_a   = rd_top_reg;
            ramp_b   = rd_bottom_reg;
            ramp_pos = D_W'(drain_y_reg);
            ramp_d   = D_W'(d_h);
        end else begin
            ramp_a   = rd_left_reg;
            ramp_b   = rd_right_reg;
            ramp_pos = D_W'(drain_x_reg);
            ramp_d   = D_W'(d_w);
        end
    end

    // Shared multiplier: a*(d-pos) first, then b*pos
    assign mul_a     = (state_reg == ST_MULB) ? ramp_b : ramp_a;
    assign mul_b     = (state_reg == ST_MULB) ? ramp_pos : (ramp_d - ramp_pos);
    assign mul_p     = NUM_W'(mul_a) * NUM_W'(mul_b);
    assign div_num   = prod_reg + mul_p + NUM_W'(ramp_d >> 1);
    assign div_start = (state_reg == ST_MULB);

    gli_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (ramp_d),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Hold first product and the ramp results
    always_ff @(posedge aclk) begin
        if (state_reg == ST_MULA) begin
            prod_reg <= mul_p;
        end
        if ((state_reg == ST_DIV) && div_done) begin
            if (phase_v_reg) begin
                vv_reg <= div_quo;
            end else begin
                hv_reg <= div_quo;
            end
        end
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        phase_v_next = phase_v_reg;
        case (state_reg)
            ST_IDLE: begin
                if (drain_accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                phase_v_next = mode_v;
                state_next   = small_grid ? ST_FIN : ST_MULA;
            end
            ST_MULA: state_next = ST_MULB;
            ST_MULB: state_next = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    if (!phase_v_reg && mode_avg) begin
                        phase_v_next = 1'b1;
                        state_next   = ST_MULA;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_v_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_v_reg <= phase_v_next;
        end
    end

    // Result select: stored sample for small grids, else by mode
    always_comb begin
        if (drain_y_reg == '0) begin
            pass_value = rd_top_reg;
        end else if (drain_y_reg == d_h) begin
            pass_value = rd_bottom_reg;
        end else if (drain_x_reg == '0) begin
            pass_value = rd_left_reg;
        end else begin
            pass_value = rd_right_reg;
        end
        avg_sum = {1'b0, hv_reg} + {1'b0, vv_reg} + (SAMPLE_W + 1)'(1);
        if (small_grid) begin
            result_value = pass_value;
        end else if (mode_h) begin
            result_value = hv_reg;
        end else if (mode_v) begin
            result_value = vv_reg;
        end else begin
            result_value = avg_sum[SAMPLE_W:1];
        end
        result_last = (drain_x_reg == d_w) && (drain_y_reg == d_h);
    end

    // Output register: load on finish, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_write) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_write) begin
            m_value_reg <= result_value;
            m_last_reg  <= result_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;
    assign m_last  = m_last_reg;

    // Assertions
    `GLI_ASSERT(a_div_done_in_div, div_done |-> (state_reg == ST_DIV), "divider done outside wait")
    `GLI_ASSERT(a_drain_reads, drain_accept |=> (state_reg == ST_READ), "drain word not read")
    `GLI_ASSERT(a_fin_holds, ((state_reg == ST_FIN) && m_valid && !m_ready) |=> (state_reg == ST_FIN), "result overwritten while stalled")
    `GLI_ASSERT(a_reset_idle, !$past(aresetn) |-> (state_reg == ST_IDLE) && !m_valid, "not idle after reset")

endmodule
